/* rtl/mssa_pkg.sv */
// ----------------------------------------------------------------------------
// Motion state package
// Mode codes, register indexes and the result types shared by the block.
// ----------------------------------------------------------------------------
package mssa_pkg;

  typedef enum logic [1:0] {
    MODE_MOVE = 2'd0,
    MODE_STOP = 2'd1,
    MODE_PARK = 2'd2
  } mode_t;

  localparam logic [1:0] CFG_MIN_SPEED = 2'd0;
  localparam logic [1:0] CFG_STOP_MS   = 2'd1;
  localparam logic [1:0] CFG_PARK_MS   = 2'd2;

  localparam int SPEED_W = 16;
  localparam int TIME_W  = 32;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  typedef struct packed {
    mode_t state;
    logic  last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

/* rtl/mssa_rq.sv */
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results per cycle while it signals room and returns one while the reader is ready.
// ----------------------------------------------------------------------------
module mssa_rq
  import mssa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t                mem_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_r;
  logic [RQ_PTR_W-1:0] rd_r;
  logic [RQ_CNT_W-1:0] count_r;
  logic [RQ_CNT_W-1:0] count_nxt;
  logic                pop;

  always_comb begin
    out_valid = (count_r != '0);
    out_res   = mem_r[rd_r];
    pop       = out_valid && out_ready;
    room      = (count_r <= RQ_CNT_W'(RQ_DEPTH - 2)) ||
                ((count_r == RQ_CNT_W'(RQ_DEPTH - 1)) && pop);
    count_nxt = count_r + RQ_CNT_W'(push.cnt) - RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_r + RQ_PTR_W'(push.cnt);
      rd_r    <= rd_r + RQ_PTR_W'(pop);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_r + RQ_PTR_W'(1)] <= push.r1;
    end
  end

endmodule

/* rtl/motion_state_from_speed_average.sv */
// ----------------------------------------------------------------------------
// Motion state from speed average
// Averages speed samples over a sliding window and reports move, stop and
// park transitions from the time elapsed since the last movement.
// ----------------------------------------------------------------------------
// A result passes through the sample stage register and the four-entry result
// queue before it is offered; a full queue holds it in the sample stage.
// Samples are taken one per cycle while the queue has room; results leave one
// per cycle while out_tready is high, so the two results of a sample (park,
// then move) leave one after the other.
// Reset (synchronous, active low) clears the window, the sum, the last
// movement time, the mode (move) and the registers to their defaults.
module motion_state_from_speed_average
  import mssa_pkg::*;
#(
  parameter int WINDOW_LENGTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] speed_sample, [47:16] time_ms
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] motion_state, [7:2] zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SUM_W = SPEED_W + $clog2(WINDOW_LENGTH);

  logic [SPEED_W-1:0] min_speed_r;
  logic [TIME_W-1:0]  stop_ms_r;
  logic [TIME_W-1:0]  park_ms_r;

  logic [SPEED_W-1:0] window_r [WINDOW_LENGTH];
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic               a_valid_r;
  logic [TIME_W-1:0]  a_time_r;
  logic [TIME_W-1:0]  last_time_r;
  logic [TIME_W-1:0]  last_time_nxt;
  mode_t              mode_r;
  mode_t              mode_nxt;

  logic               in_take;
  logic               a_take;
  logic               room;
  logic               moving;
  logic [SUM_W-1:0]   limit;
  logic [TIME_W-1:0]  elapsed;
  logic               below_stop;
  logic               park_hit;
  push_t              push;
  res_t               head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r <= SPEED_W'(300);
      stop_ms_r   <= TIME_W'(10000);
      park_ms_r   <= TIME_W'(300000);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_SPEED: min_speed_r <= cfg_data[SPEED_W-1:0];
        CFG_STOP_MS:   stop_ms_r   <= cfg_data;
        CFG_PARK_MS:   park_ms_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    a_take    = a_valid_r && room;
    in_tready = !a_valid_r || a_take;
    in_take   = in_tvalid && in_tready;
    sum_nxt   = sum_r - SUM_W'(window_r[WINDOW_LENGTH-1]) + SUM_W'(in_tdata[15:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        window_r[i] <= '0;
      end
      sum_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        window_r[0] <= in_tdata[15:0];
        for (int i = 1; i < WINDOW_LENGTH; i++) begin
          window_r[i] <= window_r[i-1];
        end
        sum_r <= sum_nxt;
      end
      a_valid_r <= in_take || (a_valid_r && !a_take);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_time_r <= in_tdata[47:16];
    end
  end

  always_comb begin
    limit         = SUM_W'(min_speed_r) * SUM_W'(WINDOW_LENGTH);
    moving        = sum_r > limit;
    last_time_nxt = moving ? a_time_r : last_time_r;
    elapsed       = moving ? '0 : a_time_r - last_time_r;
    below_stop    = elapsed < stop_ms_r;
    park_hit      = elapsed >= park_ms_r;

    mode_nxt = mode_r;
    push     = '0;
    push.r0  = '{state: MODE_MOVE, last: 1'b1};
    push.r1  = '{state: MODE_MOVE, last: 1'b1};
    case (mode_r)
      MODE_STOP: begin
        if (park_hit && below_stop) begin
          mode_nxt = MODE_MOVE;
          push.cnt = 2'd2;
          push.r0  = '{state: MODE_PARK, last: 1'b0};
        end else if (park_hit) begin
          mode_nxt = MODE_PARK;
          push.cnt = 2'd1;
          push.r0  = '{state: MODE_PARK, last: 1'b1};
        end else if (below_stop) begin
          mode_nxt = MODE_MOVE;
          push.cnt = 2'd1;
        end
      end
      MODE_PARK: begin
        if (below_stop) begin
          mode_nxt = MODE_MOVE;
          push.cnt = 2'd1;
        end
      end
      default: begin
        if (!below_stop) begin
          mode_nxt = MODE_STOP;
          push.cnt = 2'd1;
          push.r0  = '{state: MODE_STOP, last: 1'b1};
        end
      end
    endcase
    if (!a_take) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      mode_r      <= MODE_MOVE;
    end else if (a_take) begin
      last_time_r <= last_time_nxt;
      mode_r      <= mode_nxt;
    end
  end

  mssa_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign out_tdata = {6'b0, head.state};
  assign out_tlast = head.last;

endmodule

/* rtl/mssa_checker.sv */
// ----------------------------------------------------------------------------
// Motion state port checker
// Watches the top level's result port over time and reports rule breaks.
// ----------------------------------------------------------------------------
module mssa_checker
  import mssa_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // A stalled result keeps its content.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Only the three modes are ever announced.
  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'd0 && out_tdata[1:0] != 2'd3)
    else $error("undefined mode announced");

  // A transaction that is not the last of its sample can only be a park.
  a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[1:0] == MODE_PARK)
    else $error("non-final result is not park");

  // The result following a non-final park is the final move.
  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tlast && out_tdata[1:0] == MODE_MOVE)
    else $error("park is not followed by move");

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind motion_state_from_speed_average mssa_checker u_mssa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
